### src/set_assoc_cache_lru_sim_defines.svh
// Assertion macros shared by the cache simulator RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_SIM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SACL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sacl_pkg.sv
// Package for the set-associative LRU cache simulator: payload structs,
// configuration layout, access and outcome codes. Depends on nothing.
package sacl_pkg;

    localparam int ADDR_W      = 32;
    localparam int CNT_W       = 32;
    localparam int WAYS_W      = 4;
    localparam int WAY_OUT_W   = 3;
    // The set_bits register is three bits wide, so no set index exceeds seven bits.
    localparam int SET_FIELD_W = 7;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SET_BITS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WAYS       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_BLOCK_BITS = 2'd2;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_STORE  = 2'd1;
    localparam logic [1:0] ACT_MODIFY = 2'd2;

    localparam logic [1:0] OUTC_HIT   = 2'd0;
    localparam logic [1:0] OUTC_FILL  = 2'd1;
    localparam logic [1:0] OUTC_EVICT = 2'd2;

    typedef struct packed {
        logic [2:0]        set_bits;
        logic [WAYS_W-1:0] ways_in_use;
        logic [4:0]        block_bits;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           outcome;
        logic                 extra_hit;
        logic [WAY_OUT_W-1:0] way_used;
        logic [CNT_W-1:0]     hit_total;
        logic [CNT_W-1:0]     miss_total;
        logic [CNT_W-1:0]     eviction_total;
    } out_item_t;

    // A decoded access as it waits between the front end and the back end.
    typedef struct packed {
        logic                   modify;
        logic [SET_FIELD_W-1:0] set_idx;
        logic [ADDR_W-1:0]      tag;
        logic [WAYS_W-1:0]      ways;
    } job_t;

endpackage

### src/set_assoc_cache_lru_sim.sv
// Top level of the tag-only set-associative cache simulator with LRU replacement.
// Depends on sacl_pkg, sacl_front, sacl_queue, sacl_back and the assertion header.
//
// Each access transfer carries a kind (load, store, modify) and a byte address
// and produces exactly one result transfer: hit, fill of an empty way, or
// eviction, the way involved, and saturating hit, miss and eviction totals.
// After reset the block sweeps all 2**MAX_SET_BITS sets of its set memory
// once (64 with the default), one set per cycle; no access transfer is
// taken during the sweep, while configuration writes are. A front end decodes
// set and tag and places the access in a two-entry queue; the back end then
// reads the set's row from memory and afterwards compares all ways in
// parallel, ages and replaces, and writes the row back once the output
// register can take the result. The back end takes no new access from the
// queue before that write-back, and since the next row read comes after the
// write, accesses to the same set follow each other correctly. An access
// passes through the queue, the row and job registers and the output register
// before its result is shown. A result waiting in the output register does
// not keep the front end from taking further accesses until the queue is full.
// Configuration registers (index 0 set_bits, 1 ways_in_use, 2 block_bits) are
// to be written only while no access is outstanding.
`include "set_assoc_cache_lru_sim_defines.svh"

module set_assoc_cache_lru_sim
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data
);

    cfg_t cfg_reg;
    logic clearing;
    logic push_valid;
    logic push_ready;
    job_t push_data;
    logic q_valid;
    logic q_ready;
    job_t q_data;

    // Configuration writes are always taken; an index past the list is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_bits    <= '0;
            cfg_reg.ways_in_use <= WAYS_W'(1);
            cfg_reg.block_bits  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_IDX_SET_BITS:   cfg_reg.set_bits    <= cfg_data[2:0];
                CFG_IDX_WAYS:       cfg_reg.ways_in_use <= cfg_data[WAYS_W-1:0];
                CFG_IDX_BLOCK_BITS: cfg_reg.block_bits  <= cfg_data;
                default:            cfg_reg             <= cfg_reg;
            endcase
        end
    end

    sacl_front #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_front (
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    sacl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    sacl_back #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_valid),
        .pop_ready (q_ready),
        .pop_data  (q_data),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The hit total never goes backward while results are shown back to back.
    `SACL_ASSERT_NOW(a_hits_grow, out_valid && $past(out_valid), out_data.hit_total >= $past(out_data.hit_total), "hit total went backward")

    // Every eviction is also counted as a miss.
    `SACL_ASSERT_NOW(a_evict_le_miss, out_valid, out_data.eviction_total <= out_data.miss_total, "eviction total exceeds miss total")

    // Once a row read is issued, no other access is taken before the write-back.
    `SACL_ASSERT_NEXT(a_one_row_in_flight, q_valid && q_ready, !q_ready, "second access taken before row write-back")

endmodule

### src/sacl_front.sv
// Front end of the cache simulator: takes accesses and splits the address
// into set and tag under the current configuration. Depends on sacl_pkg.
module sacl_front
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
)
(
    input  cfg_t     cfg,
    input  logic     clearing,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output job_t     push_data
);

    logic [2:0]             sb;
    logic [WAYS_W-1:0]      ways;
    logic [5:0]             shift;
    logic [ADDR_W-1:0]      by_block;
    logic [SET_FIELD_W-1:0] set_mask;

    // Nothing is taken while the back end sweeps its memory after reset.
    assign in_ready   = push_ready && !clearing;
    assign push_valid = in_valid && !clearing;

    always_comb
    begin
        if (int'(cfg.set_bits) > MAX_SET_BITS)
        begin
            sb = 3'(MAX_SET_BITS);
        end
        else
        begin
            sb = cfg.set_bits;
        end

        if (cfg.ways_in_use == '0)
        begin
            ways = WAYS_W'(1);
        end
        else if (int'(cfg.ways_in_use) > MAX_WAYS)
        begin
            ways = WAYS_W'(MAX_WAYS);
        end
        else
        begin
            ways = cfg.ways_in_use;
        end

        shift    = 6'(sb) + 6'(cfg.block_bits);
        by_block = in_data.address >> cfg.block_bits;
        for (int i = 0; i < SET_FIELD_W; i++)
        begin
            set_mask[i] = (i < int'(sb));
        end

        push_data.modify  = (in_data.action == ACT_MODIFY);
        push_data.set_idx = by_block[SET_FIELD_W-1:0] & set_mask;
        push_data.tag     = (shift >= 6'(ADDR_W)) ? '0 : (in_data.address >> shift);
        push_data.ways    = ways;
    end

endmodule

### src/sacl_queue.sv
// Two-entry queue of decoded accesses between front end and back end.
// Depends on sacl_pkg.
module sacl_queue
    import sacl_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_data
);

    job_t                   entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push;
    logic                   pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/sacl_back.sv
// Back end of the cache simulator: set memory, tag compare, LRU update,
// totals and the result register. Depends on sacl_pkg.
module sacl_back
    import sacl_pkg::*;
#(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  job_t      pop_data,
    output logic      clearing,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = WAY_W;
    localparam int AW       = WAYS_W + 1;
    localparam int CW1      = CNT_W + 1;

    typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EVAL} state_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][AGE_W-1:0]  age;
        logic [MAX_WAYS-1:0][ADDR_W-1:0] tag;
    } row_t;

    row_t                           mem [NUM_SETS];
    row_t                           rdata_reg;
    row_t                           row_next;
    row_t                           mem_wdata;
    logic [SET_W-1:0]               mem_waddr;
    logic                           mem_we;
    state_t                         state_reg;
    logic [SET_W-1:0]               clr_reg;
    job_t                           job_reg;
    logic                           out_valid_reg;
    out_item_t                      out_data_reg;
    out_item_t                      out_next;
    logic [CNT_W-1:0]               hits_reg;
    logic [CNT_W-1:0]               misses_reg;
    logic [CNT_W-1:0]               evictions_reg;
    logic [CNT_W-1:0]               hits_next;
    logic [CNT_W-1:0]               misses_next;
    logic [CNT_W-1:0]               evictions_next;
    logic [1:0]                     hit_add;
    logic [CW1-1:0]                 hit_sum;
    logic                           take_job;
    logic                           finish;
    logic [MAX_WAYS-1:0]            in_use;
    logic [MAX_WAYS-1:0]            hit_vec;
    logic [MAX_WAYS-1:0][AGE_W-1:0] aged;
    logic [AW-1:0]                  age_lim;
    logic [AW-1:0]                  age_inc;
    logic                           hit_found;
    logic                           empty_found;
    logic [WAY_W-1:0]               hit_way;
    logic [WAY_W-1:0]               empty_way;
    logic [WAY_W-1:0]               victim;
    logic [WAY_W-1:0]               way_sel;
    logic [1:0]                     outcome;

    assign clearing  = (state_reg == ST_CLEAR);
    assign pop_ready = (state_reg == ST_IDLE);
    assign take_job  = pop_valid && pop_ready;
    // The row is written back only when the result register can take the result.
    assign finish    = (state_reg == ST_EVAL) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Tag compare, aging and replacement for the row registered when the access was taken.
    always_comb
    begin
        hit_found   = 1'b0;
        hit_way     = '0;
        empty_found = 1'b0;
        empty_way   = '0;
        victim      = '0;
        age_inc     = '0;
        age_lim     = AW'(job_reg.ways) - AW'(1);

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w]  = (WAYS_W'(w) < job_reg.ways);
            hit_vec[w] = in_use[w] && rdata_reg.valid[w] && (rdata_reg.tag[w] == job_reg.tag);
        end

        // Lowest-numbered matching way wins.
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (hit_vec[w])
            begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
        end

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            aged[w] = rdata_reg.age[w];
            if (in_use[w] && rdata_reg.valid[w] && !(hit_found && (hit_way == WAY_W'(w))))
            begin
                age_inc = AW'(rdata_reg.age[w]) + AW'(1);
                aged[w] = (age_inc >= age_lim) ? AGE_W'(age_lim) : AGE_W'(age_inc);
            end
        end

        // Highest empty way; among the oldest ways the highest-numbered one.
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && !rdata_reg.valid[w])
            begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(w);
            end
            else if (in_use[w] && (aged[w] >= aged[victim]))
            begin
                victim = WAY_W'(w);
            end
        end

        row_next     = rdata_reg;
        row_next.age = aged;
        if (hit_found)
        begin
            way_sel = hit_way;
            outcome = OUTC_HIT;
        end
        else if (empty_found)
        begin
            way_sel = empty_way;
            outcome = OUTC_FILL;
        end
        else
        begin
            way_sel = victim;
            outcome = OUTC_EVICT;
        end
        row_next.age[way_sel] = '0;
        if (!hit_found)
        begin
            row_next.valid[way_sel] = 1'b1;
            row_next.tag[way_sel]   = job_reg.tag;
        end
    end

    always_comb
    begin
        hit_add   = {1'b0, job_reg.modify} + {1'b0, hit_found};
        hit_sum   = CW1'(hits_reg) + CW1'(hit_add);
        hits_next = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];

        misses_next = misses_reg;
        if (!hit_found && (misses_reg != '1))
        begin
            misses_next = misses_reg + CNT_W'(1);
        end

        evictions_next = evictions_reg;
        if ((outcome == OUTC_EVICT) && (evictions_reg != '1))
        begin
            evictions_next = evictions_reg + CNT_W'(1);
        end

        out_next.outcome        = outcome;
        out_next.extra_hit      = job_reg.modify;
        out_next.way_used       = WAY_OUT_W'(way_sel);
        out_next.hit_total      = hits_next;
        out_next.miss_total     = misses_next;
        out_next.eviction_total = evictions_next;
    end

    always_comb
    begin
        mem_we    = clearing || finish;
        mem_waddr = clearing ? clr_reg : SET_W'(job_reg.set_idx);
        mem_wdata = clearing ? '0 : row_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (take_job)
        begin
            rdata_reg <= mem[SET_W'(pop_data.set_idx)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_job)
        begin
            job_reg <= pop_data;
        end
        if (finish)
        begin
            out_data_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + SET_W'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (pop_valid)
                    begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    if (finish)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (finish)
            begin
                out_valid_reg <= 1'b1;
                hits_reg      <= hits_next;
                misses_reg    <= misses_next;
                evictions_reg <= evictions_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### verif/testbench.sv
// Self-checking testbench for the set-associative LRU cache simulator.
// Depends on sacl_pkg and set_assoc_cache_lru_sim; it predicts every result
// transfer from its own tag, age and counter model and compares field by field.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sacl_pkg::*;

    // Geometry of the block as instantiated with its default parameters.
    localparam int SETS         = 64;
    localparam int WAYS_MAX     = 8;
    localparam int SET_BITS_MAX = 6;

    // Run control. The idle limit covers the post-reset sweep, the longest
    // sender gap plus the longest receiver stall, and the deliberate hold-off,
    // several times over.
    localparam int IDLE_LIMIT       = 2000;
    localparam int HOLD_CYCLES      = 200;
    localparam int DRAIN_CYCLES     = 10;
    localparam int RANDOM_PHASES    = 8;
    localparam int ITEMS_PER_PHASE  = 115;
    localparam int PRESSURE_ITEMS   = 60;
    localparam int REPORT_LIMIT     = 10;

    // Register index that the block does not decode, and the spare access code.
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam logic [1:0]             ACT_SPARE      = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;

    // Shadow copies of the three configuration registers, as written.
    logic [2:0] set_bits_reg;
    logic [3:0] ways_reg;
    logic [4:0] block_bits_reg;

    // Shadow cache state: one row of ways per set, plus the running totals.
    bit          tag_valid [SETS][WAYS_MAX];
    logic [31:0] tag_store [SETS][WAYS_MAX];
    int          way_age   [SETS][WAYS_MAX];
    logic [31:0] hits_seen;
    logic [31:0] misses_seen;
    logic [31:0] evictions_seen;

    // Results predicted at each accepted access transfer, oldest first.
    out_item_t expected_results [$];
    out_item_t oldest_result;

    int  accesses_sent;
    int  results_checked;
    int  reg_writes;
    int  fail_count;
    int  idle_cycles;
    bit  steady_flow;
    bit  hold_request;

    set_assoc_cache_lru_sim u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Cache prediction
    // ------------------------------------------------------------------

    function automatic logic [31:0] sat_up(input logic [31:0] count);
        return (count == 32'hFFFF_FFFF) ? count : count + 32'd1;
    endfunction

    // Applies one access to the shadow cache and returns the result that the
    // block must produce for it. The hit search takes the lowest matching way,
    // every other valid way in use ages by one up to ways-1, and a miss fills
    // the highest empty way or else evicts the oldest, the highest one on ties.
    function automatic out_item_t predict_access(input in_item_t access);
        int          sb;
        int          bb;
        int          ways;
        int          set_idx;
        int          hit_way;
        int          empty_way;
        int          victim;
        int          way;
        int          w;
        logic [31:0] tag;
        out_item_t   res;

        sb = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
        bb = int'(block_bits_reg);
        if (ways_reg == 4'd0)
            ways = 1;
        else if (ways_reg > WAYS_MAX)
            ways = WAYS_MAX;
        else
            ways = int'(ways_reg);

        // Once the offset and the set index cover the whole address, the tag
        // is zero for every access.
        tag     = (sb + bb >= 32) ? 32'd0 : access.address >> (sb + bb);
        set_idx = int'((access.address >> bb) & ((32'd1 << sb) - 32'd1));

        hit_way   = -1;
        empty_way = -1;
        victim    = 0;

        // A modify counts its second hit whether or not the first one hits.
        if (access.action == ACT_MODIFY)
            hits_seen = sat_up(hits_seen);

        for (w = 0; w < ways; w++)
        begin
            if (hit_way < 0 && tag_valid[set_idx][w] && tag_store[set_idx][w] == tag)
                hit_way = w;
        end

        for (w = 0; w < ways; w++)
        begin
            if (tag_valid[set_idx][w] && w != hit_way)
                way_age[set_idx][w] = (way_age[set_idx][w] + 1 >= ways - 1) ?
                                      ways - 1 : way_age[set_idx][w] + 1;
        end

        res = '0;
        if (hit_way >= 0)
        begin
            way_age[set_idx][hit_way] = 0;
            hits_seen   = sat_up(hits_seen);
            res.outcome = OUTC_HIT;
            way         = hit_way;
        end
        else
        begin
            for (w = 0; w < ways; w++)
            begin
                if (!tag_valid[set_idx][w])
                    empty_way = w;
                else if (way_age[set_idx][w] >= way_age[set_idx][victim])
                    victim = w;
            end
            if (empty_way >= 0)
            begin
                way         = empty_way;
                res.outcome = OUTC_FILL;
            end
            else
            begin
                way            = victim;
                res.outcome    = OUTC_EVICT;
                evictions_seen = sat_up(evictions_seen);
            end
            tag_valid[set_idx][way] = 1'b1;
            tag_store[set_idx][way] = tag;
            way_age[set_idx][way]   = 0;
            misses_seen = sat_up(misses_seen);
        end

        res.extra_hit      = (access.action == ACT_MODIFY);
        res.way_used       = WAY_OUT_W'(way);
        res.hit_total      = hits_seen;
        res.miss_total     = misses_seen;
        res.eviction_total = evictions_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    function automatic logic [1:0] pick_action();
        int r;
        r = $urandom_range(0, 15);
        if (r < 5)
            return ACT_LOAD;
        else if (r < 10)
            return ACT_STORE;
        else if (r < 15)
            return ACT_MODIFY;
        else
            return ACT_SPARE;
    endfunction

    // Most addresses are built from a small pool of tags and a few sets under
    // the current register settings, so that sets fill up, hit and evict. The
    // rest are fully random addresses.
    function automatic logic [31:0] make_address();
        int          sb;
        int          bb;
        int          tag_pick;
        int          set_pick;
        logic [63:0] addr;

        if ($urandom_range(0, 4) == 0)
            return $urandom;
        sb       = (set_bits_reg > SET_BITS_MAX) ? SET_BITS_MAX : int'(set_bits_reg);
        bb       = int'(block_bits_reg);
        tag_pick = $urandom_range(0, 11);
        set_pick = ($urandom_range(0, 4) == 0) ? $urandom_range(0, SETS - 1)
                                               : $urandom_range(0, 1);
        set_pick = set_pick & ((1 << sb) - 1);
        addr = (64'(tag_pick) << (sb + bb)) | (64'(set_pick) << bb)
             | (64'($urandom) & ((64'd1 << bb) - 64'd1));
        return addr[31:0];
    endfunction

    // Offers one access transfer after an optional gap and waits until it is
    // taken. Valid stays high between back-to-back transfers.
    task automatic send_access(input logic [1:0] action, input logic [31:0] address);
        int       gap;
        in_item_t access;

        access.action  = action;
        access.address = address;
        gap = steady_flow ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= access;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(predict_access(access));
        accesses_sent++;
    endtask

    task automatic end_stream();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // One register write transfer; the caller lowers valid afterwards.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (index)
            CFG_IDX_SET_BITS:   set_bits_reg   = value[2:0];
            CFG_IDX_WAYS:       ways_reg       = value[3:0];
            CFG_IDX_BLOCK_BITS: block_bits_reg = value[4:0];
            default:            ;
        endcase
        reg_writes++;
    endtask

    // Writes all three registers. It is only called while no access is
    // outstanding, which is the rule the block sets for configuration.
    task automatic configure(input logic [CFG_DATA_W-1:0] set_bits,
                             input logic [CFG_DATA_W-1:0] ways,
                             input logic [CFG_DATA_W-1:0] block_bits);
        write_reg(CFG_IDX_SET_BITS, set_bits);
        write_reg(CFG_IDX_WAYS, ways);
        write_reg(CFG_IDX_BLOCK_BITS, block_bits);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // One set of one way: fill, a modify that hits, an eviction by the
    // all-ones address, and the spare access code behaving as a load. A write
    // to the undecoded register index comes first and must change nothing.
    task automatic test_default_config();
        write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom_range(0, 31)));
        configure(5'd0, 5'd1, 5'd0);
        send_access(ACT_LOAD, 32'h0000_0000);
        send_access(ACT_MODIFY, 32'h0000_0000);
        send_access(ACT_STORE, 32'hFFFF_FFFF);
        send_access(ACT_SPARE, 32'hFFFF_FFFF);
        end_stream();
        wait_drained();
    endtask

    // A set_bits value above the maximum and a way count above the maximum
    // both saturate. Nine tags into one set fill all eight ways and then
    // evict the oldest. Dropping to two ways afterwards leaves ages above the
    // new limit, which clamp the next time those ways age, while the ways
    // beyond the count in use keep their contents.
    task automatic test_lru_order();
        int t;
        configure(5'd7, 5'd15, 5'd0);
        for (t = 0; t < 9; t++)
            send_access(t % 3 == 0 ? ACT_LOAD : (t % 3 == 1 ? ACT_STORE : ACT_MODIFY),
                        (32'(t) << 6) | 32'd5);
        end_stream();
        wait_drained();
        configure(5'd6, 5'd2, 5'd0);
        send_access(ACT_LOAD, (32'd20 << 6) | 32'd5);
        send_access(ACT_LOAD, (32'd3 << 6) | 32'd5);
        end_stream();
        wait_drained();
    endtask

    // With the widest offset the set index and offset cover the address, so
    // every tag is zero. A way count of zero behaves as one way.
    task automatic test_wide_offset();
        configure(5'd6, 5'd0, 5'd31);
        send_access(ACT_LOAD, 32'h8000_0000);
        send_access(ACT_STORE, 32'h0000_0001);
        send_access(ACT_MODIFY, 32'hFFFF_FFFF);
        end_stream();
        wait_drained();
    endtask

    // One tag goes into the upper way of a two-way set; with only one way in
    // use the same tag misses and lands in the lower way too. With both ways
    // back in use the access matches twice, and the lower way must win.
    task automatic test_duplicate_tags();
        configure(5'd0, 5'd2, 5'd0);
        send_access(ACT_LOAD, 32'h0000_0100);
        end_stream();
        wait_drained();
        configure(5'd0, 5'd1, 5'd0);
        send_access(ACT_LOAD, 32'h0000_0100);
        end_stream();
        wait_drained();
        configure(5'd0, 5'd2, 5'd0);
        send_access(ACT_LOAD, 32'h0000_0100);
        end_stream();
        wait_drained();
    endtask

    // Random traffic in phases, each with its own register settings. The
    // first phases take the extremes, the rest are random, and every third
    // phase runs with no idling on either side.
    task automatic test_random_traffic();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       configure(5'd0, 5'd1, 5'd0);
                1:       configure(5'd6, 5'd8, 5'd0);
                2:       configure(5'd31, 5'd15, 5'd25);
                default: configure(CFG_DATA_W'($urandom_range(0, 31)),
                                   CFG_DATA_W'($urandom_range(0, 31)),
                                   ($urandom_range(0, 1) == 1) ?
                                       CFG_DATA_W'($urandom_range(0, 8)) :
                                       CFG_DATA_W'($urandom_range(0, 31)));
            endcase
            steady_flow = (phase % 3 == 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_access(pick_action(), make_address());
            end_stream();
            wait_drained();
            steady_flow = 1'b0;
        end
    endtask

    // The receiver holds off for a long stretch while accesses keep coming
    // back to back, so the queue and output register fill and in_ready drops.
    task automatic test_backpressure();
        int n;
        configure(5'd2, 5'd4, 5'd3);
        steady_flow  = 1'b1;
        hold_request = 1'b1;
        for (n = 0; n < PRESSURE_ITEMS; n++)
            send_access(pick_action(), make_address());
        end_stream();
        wait_drained();
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, no stalls in steady phases, and the long
    // hold-off when a test asks for it. The hold is counted here.
    // ------------------------------------------------------------------
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each result transfer is compared with the oldest
    // prediction. Only the first few failures are printed in full.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("%0t: result transfer with no access outstanding: %p",
                             $realtime, out_data);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (out_data.outcome !== oldest_result.outcome ||
                    out_data.extra_hit !== oldest_result.extra_hit ||
                    out_data.way_used !== oldest_result.way_used ||
                    out_data.hit_total !== oldest_result.hit_total ||
                    out_data.miss_total !== oldest_result.miss_total ||
                    out_data.eviction_total !== oldest_result.eviction_total)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result %0d mismatch", $realtime, results_checked);
                        $display("    expected outcome %0d extra %0d way %0d hits %0d misses %0d evictions %0d",
                                 oldest_result.outcome, oldest_result.extra_hit,
                                 oldest_result.way_used, oldest_result.hit_total,
                                 oldest_result.miss_total, oldest_result.eviction_total);
                        $display("    actual   outcome %0d extra %0d way %0d hits %0d misses %0d evictions %0d",
                                 out_data.outcome, out_data.extra_hit, out_data.way_used,
                                 out_data.hit_total, out_data.miss_total,
                                 out_data.eviction_total);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: ends the run if no transfer of any kind happens for too long.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles, %0d results still expected",
                     IDLE_LIMIT, expected_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        // The shadow cache starts empty with the registers at their reset
        // values, exactly as the block leaves reset.
        set_bits_reg   = 3'd0;
        ways_reg       = 4'd1;
        block_bits_reg = 5'd0;
        hits_seen      = '0;
        misses_seen    = '0;
        evictions_seen = '0;
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS_MAX; w++)
            begin
                tag_valid[s][w] = 1'b0;
                tag_store[s][w] = '0;
                way_age[s][w]   = 0;
            end

        accesses_sent   = 0;
        results_checked = 0;
        reg_writes      = 0;
        fail_count      = 0;
        idle_cycles     = 0;
        steady_flow     = 1'b0;
        hold_request    = 1'b0;

        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        rst_n     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // The block sweeps its set memory after reset and holds in_ready low
        // meanwhile; the first access transfer simply waits for it.
        test_default_config();
        test_lru_order();
        test_wide_offset();
        test_duplicate_tags();
        test_random_traffic();
        test_backpressure();

        // Everything predicted has arrived; wait out the drain period so a
        // stray extra result would still be caught.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_results.size();

        $display("Checked %0d results for %0d accesses across %0d register writes, with a %0d-cycle output hold.",
                 results_checked, accesses_sent, reg_writes, HOLD_CYCLES);
        $display("Predicted totals at the end: %0d hits, %0d misses, %0d evictions; %0d failures.",
                 hits_seen, misses_seen, evictions_seen, fail_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
